### hdl/cgn_pkg.sv
// cgn_pkg: shared types and constants for the gradient non-maximum suppression block
// no dependencies
package cgn_pkg;

	// default sizes
	localparam int DEF_MAX_WIDTH   = 2048;
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int MAX_HEIGHT      = 4096;

	// tangent thresholds in q16
	localparam logic [17:0] TAN_LO_Q16 = 18'd27145;
	localparam logic [17:0] TAN_HI_Q16 = 18'd158217;

	// configuration register indexes
	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	// reset values of the registers
	localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
	localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;

	// direction codes
	localparam logic [1:0] DIR_0   = 2'd0;
	localparam logic [1:0] DIR_45  = 2'd1;
	localparam logic [1:0] DIR_90  = 2'd2;
	localparam logic [1:0] DIR_135 = 2'd3;

	// control state
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQ   = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

### hdl/cgn_ifs.sv
// cgn_ifs: stream channels of the gradient non-maximum suppression block
// depends on nothing; the input channel widths follow the sample width parameter, the output widths are fixed
interface cgn_in_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] grad_x;
	logic signed [SAMPLE_BITS-1:0] grad_y;
	logic                          frame_start;
	modport source (output valid, grad_x, grad_y, frame_start, input ready);
	modport sink (input valid, grad_x, grad_y, frame_start, output ready);
endinterface

interface cgn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] suppressed_magnitude;
	logic [10:0] center_col;
	logic [11:0] center_row;
	logic [1:0]  direction_code;
	logic        last_of_frame;
	modport source (output valid, suppressed_magnitude, center_col, center_row,
		direction_code, last_of_frame, input ready);
	modport sink (input valid, suppressed_magnitude, center_col, center_row,
		direction_code, last_of_frame, output ready);
endinterface

### hdl/canny_gradient_nms.sv
// a request passes through the square, sum, root and done states; its result is registered on leaving done
// requests are taken only in the idle state, so a new request waits until the last one is through;
// a pending result stalls a request in its done state until the result is taken
// the square root unit takes one result bit per cycle, then the done state writes the line memory
// reset (arst_n low, asynchronous): counters, 3x3 window and control clear, registers reload
// line memories are not cleared; they are written one row ahead of every read
module canny_gradient_nms
	import cgn_pkg::*;
#(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data,
	cgn_in_if.sink      pix,
	cgn_out_if.source   res
);

	localparam int SB = SAMPLE_BITS;
	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
	localparam int AW = $clog2(2 * MAX_WIDTH);
	localparam int WW = (CW + 1 > 12) ? CW + 1 : 12;
	localparam int IW = $clog2(SB + 1);

	state_t state_q;

	// configuration registers
	logic [11:0] width_q;
	logic [12:0] height_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
		end else if (cfg_we) begin
			if (cfg_index == CFG_IMAGE_WIDTH) width_q <= cfg_data[11:0];
			else height_q <= cfg_data;
		end
	end

	// clamped frame size
	logic [WW-1:0] iw, eff_w;
	logic [12:0]   eff_h;
	always_comb begin
		iw = WW'(width_q);
		if (iw < WW'(3)) eff_w = WW'(3);
		else if (iw > WW'(MAX_WIDTH)) eff_w = WW'(MAX_WIDTH);
		else eff_w = iw;
		if (height_q < 13'd3) eff_h = 13'd3;
		else if (height_q > 13'(MAX_HEIGHT)) eff_h = 13'(MAX_HEIGHT);
		else eff_h = height_q;
	end

	logic accept;
	assign pix.ready = (state_q == ST_IDLE);
	assign accept    = pix.valid && pix.ready;

	// position and sample registers
	logic [CW-1:0] col_q, col_s1;
	logic [11:0]   row_q, row_s1;
	logic [SB-1:0] ax_s1, ay_s1;
	logic          gx_neg_s1, gy_neg_s1, gx_zero_s1, gy_zero_s1;
	logic [CW-1:0] col_in;
	logic [11:0]   row_in;
	assign col_in = pix.frame_start ? '0 : col_q;
	assign row_in = pix.frame_start ? '0 : row_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1     <= col_in;
			row_s1     <= row_in;
			ax_s1      <= pix.grad_x[SB-1] ? SB'(-pix.grad_x) : SB'(pix.grad_x);
			ay_s1      <= pix.grad_y[SB-1] ? SB'(-pix.grad_y) : SB'(pix.grad_y);
			gx_neg_s1  <= pix.grad_x[SB-1];
			gy_neg_s1  <= pix.grad_y[SB-1];
			gx_zero_s1 <= (pix.grad_x == '0);
			gy_zero_s1 <= (pix.grad_y == '0);
		end
	end

	// line memory addresses: the older row is replaced by the current one
	logic [AW-1:0] old_addr, mid_addr, wr_addr_q;
	assign old_addr = row_in[0] ? AW'(MAX_WIDTH) + AW'(col_in) : AW'(col_in);
	assign mid_addr = row_in[0] ? AW'(col_in) : AW'(MAX_WIDTH) + AW'(col_in);

	// line memories
	logic [15:0] mag_mem [2*MAX_WIDTH];
	logic [1:0]  dir_mem [2*MAX_WIDTH];
	logic [15:0] mag_old_q, mag_mid_q;
	logic [1:0]  dir_mid_q;
	logic        mem_we;
	logic [15:0] mag_fin;
	logic [1:0]  dir_q;
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_old_q <= mag_mem[old_addr];
			mag_mid_q <= mag_mem[mid_addr];
			dir_mid_q <= dir_mem[mid_addr];
			wr_addr_q <= old_addr;
		end
		if (mem_we) begin
			mag_mem[wr_addr_q] <= mag_fin;
			dir_mem[wr_addr_q] <= dir_q;
		end
	end

	// squares and tangent products
	logic [2*SB-1:0] sqx_s2, sqy_s2;
	logic [SB+17:0]  lft_s2, hi_s2, lo_s2;
	always_ff @(posedge clk) begin
		if (state_q == ST_SQ) begin
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			lft_s2 <= {2'b00, ay_s1, 16'h0000};
			hi_s2  <= TAN_HI_Q16 * ax_s1;
			lo_s2  <= TAN_LO_Q16 * ax_s1;
		end
	end

	// direction quantizer
	logic [1:0] dir_d;
	logic       same_sign;
	always_comb begin
		same_sign = gy_zero_s1 || (gx_neg_s1 == gy_neg_s1);
		if (gx_zero_s1) dir_d = gy_zero_s1 ? DIR_0 : DIR_90;
		else if (lft_s2 >= hi_s2) dir_d = DIR_90;
		else if (same_sign) dir_d = (lft_s2 <= lo_s2) ? DIR_0 : DIR_45;
		else dir_d = (lft_s2 < lo_s2) ? DIR_0 : DIR_135;
	end

	// bit-serial square root
	logic [2*SB-1:0] rem_q, root_q, bit_q, trial;
	logic [IW-1:0]   iter_q;
	assign trial = root_q + bit_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_SUM) begin
			rem_q  <= sqx_s2 + sqy_s2;
			root_q <= '0;
			bit_q  <= (2*SB)'(1) << (2*SB - 2);
			dir_q  <= dir_d;
		end else if (state_q == ST_ROOT) begin
			if (rem_q >= trial) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end
	assign mag_fin = (root_q > (2*SB)'(16'hFFFF)) ? 16'hFFFF : root_q[15:0];

	// window after the shift
	logic [15:0] win_q [9];
	logic [1:0]  wdir_q [3];
	logic [15:0] nw [9];
	logic [1:0]  nd [3];
	logic [15:0] nb_a, nb_b, ctr;
	always_comb begin
		nw[0] = win_q[1]; nw[1] = win_q[2]; nw[2] = mag_old_q;
		nw[3] = win_q[4]; nw[4] = win_q[5]; nw[5] = mag_mid_q;
		nw[6] = win_q[7]; nw[7] = win_q[8]; nw[8] = mag_fin;
		nd[0] = wdir_q[1]; nd[1] = wdir_q[2]; nd[2] = dir_mid_q;
		ctr = nw[4];
		case (nd[1])
			DIR_0:   begin nb_a = nw[3]; nb_b = nw[5]; end
			DIR_45:  begin nb_a = nw[0]; nb_b = nw[8]; end
			DIR_90:  begin nb_a = nw[1]; nb_b = nw[7]; end
			default: begin nb_a = nw[6]; nb_b = nw[2]; end
		endcase
	end

	logic out_valid_q, done_go, produce, col_wrap, row_wrap;
	assign done_go  = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	assign mem_we   = done_go;
	assign produce  = (col_s1 >= CW'(2)) && (row_s1 >= 12'd2);
	assign col_wrap = ((WW+1)'(col_s1) + (WW+1)'(1)) >= (WW+1)'(eff_w);
	assign row_wrap = (13'(row_s1) + 13'd1) >= eff_h;

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (done_go && produce) out_valid_q <= 1'b1;
		else if (res.ready) out_valid_q <= 1'b0;
	end

	// control, counters and window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			col_q       <= '0;
			row_q       <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			for (int i = 0; i < 3; i++) wdir_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_SUM;
				ST_SUM: begin
					state_q <= ST_ROOT;
					iter_q  <= IW'(SB - 1);
				end
				ST_ROOT: begin
					if (iter_q == '0) state_q <= ST_DONE;
					else iter_q <= iter_q - IW'(1);
				end
				ST_DONE: if (done_go) begin
					state_q <= ST_IDLE;
					for (int i = 0; i < 9; i++) win_q[i] <= nw[i];
					for (int i = 0; i < 3; i++) wdir_q[i] <= nd[i];
					if (col_wrap) begin
						col_q <= '0;
						row_q <= row_wrap ? 12'd0 : row_s1 + 12'd1;
					end else begin
						col_q <= col_s1 + CW'(1);
						row_q <= row_s1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	logic [15:0] o_mag_q;
	logic [10:0] o_col_q;
	logic [11:0] o_row_q;
	logic [1:0]  o_dir_q;
	logic        o_last_q;
	always_ff @(posedge clk) begin
		if (done_go && produce) begin
			o_mag_q  <= (ctr > nb_a && ctr > nb_b) ? ctr : 16'h0000;
			o_col_q  <= 11'((WW)'(col_s1) - (WW)'(1));
			o_row_q  <= row_s1 - 12'd1;
			o_dir_q  <= nd[1];
			o_last_q <= ((WW)'(col_s1) == eff_w - (WW)'(1)) &&
				(13'(row_s1) == eff_h - 13'd1);
		end
	end

	assign res.valid                = out_valid_q;
	assign res.suppressed_magnitude = o_mag_q;
	assign res.center_col           = o_col_q;
	assign res.center_row           = o_row_q;
	assign res.direction_code       = o_dir_q;
	assign res.last_of_frame        = o_last_q;

endmodule

### hdl/cgn_checker.sv
// cgn_checker: port-level assertions for canny_gradient_nms
// bound to the top level; depends on nothing else
module cgn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_mag
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_mag))
		else $error("result dropped or changed while stalled");

	// one request in flight at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a result appears only at the end of a request's work
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without finished request");

endmodule

bind canny_gradient_nms cgn_checker u_cgn_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(pix.valid), .in_ready(pix.ready),
	.out_valid(res.valid), .out_ready(res.ready),
	.out_mag(res.suppressed_magnitude)
);

### sim/tb_canny_gradient_nms.sv
// tb_canny_gradient_nms: self-checking bench for the canny non-maximum suppression block
// depends on cgn_pkg, cgn_ifs and canny_gradient_nms; predicts results in-bench, apart from typed directed rows
`timescale 1ns / 1ps

module tb_canny_gradient_nms;
	import cgn_pkg::*;

	typedef struct packed {
		logic [15:0] mag;
		logic [10:0] col;
		logic [11:0] row;
		logic [1:0]  dir;
		logic        last;
	} nms_result_t;

	typedef struct packed {
		logic signed [15:0] gx;
		logic signed [15:0] gy;
		logic               fs;
		logic               typed;
		nms_result_t        want;
	} pix_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [12:0] cfg_data;

	cgn_in_if #(.SAMPLE_BITS(16)) pix ();
	cgn_out_if res ();

	canny_gradient_nms i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .pix(pix.sink), .res(res.source)
	);

	// predicted block state
	logic [11:0] width_reg;
	logic [12:0] height_reg;
	logic [15:0] mag_line [2*DEF_MAX_WIDTH];
	logic [1:0]  dir_line [2*DEF_MAX_WIDTH];
	logic [15:0] win_mag [9];
	logic [1:0]  win_dir [3];
	int unsigned col_cnt, row_cnt;

	nms_result_t pending_results[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	bit sender_burst = 1'b0;

	always #2 clk = ~clk;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
		errors++;
	endtask

	function automatic logic [15:0] root_floor(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic [1:0] quantize(input logic signed [15:0] gx,
		input logic signed [15:0] gy);
		longint sx, sy, ax, ay, l;
		sx = gx;
		sy = gy;
		ax = (sx < 0) ? -sx : sx;
		ay = (sy < 0) ? -sy : sy;
		l = ay << 16;
		if (sx == 0) return (sy == 0) ? DIR_0 : DIR_90;
		if (l >= longint'(TAN_HI_Q16) * ax) return DIR_90;
		if (sy == 0 || ((sx > 0) == (sy > 0)))
			return (l <= longint'(TAN_LO_Q16) * ax) ? DIR_0 : DIR_45;
		return (l < longint'(TAN_LO_Q16) * ax) ? DIR_0 : DIR_135;
	endfunction

	function automatic int unsigned eff_width();
		if (width_reg < 3) return 3;
		if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		if (height_reg < 3) return 3;
		if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
		return height_reg;
	endfunction

	// advance the predicted state by one accepted request
	function automatic bit nms_step(input logic signed [15:0] gx, input logic signed [15:0] gy,
		input logic fs, output nms_result_t r);
		int unsigned w, h, c, rw, old_i, mid_i;
		longint sx, sy;
		logic [15:0] m, a, b, ctr;
		logic [1:0] d, dc;
		bit hit;
		w = eff_width();
		h = eff_height();
		if (fs) begin
			col_cnt = 0;
			row_cnt = 0;
		end
		c = col_cnt % DEF_MAX_WIDTH;
		rw = row_cnt;
		sx = gx;
		sy = gy;
		m = root_floor(longint'(sx * sx + sy * sy));
		d = quantize(gx, gy);
		old_i = (rw & 1) * DEF_MAX_WIDTH + c;
		mid_i = ((rw + 1) & 1) * DEF_MAX_WIDTH + c;
		for (int k = 0; k < 3; k++) begin
			win_mag[k*3] = win_mag[k*3+1];
			win_mag[k*3+1] = win_mag[k*3+2];
		end
		win_dir[0] = win_dir[1];
		win_dir[1] = win_dir[2];
		win_mag[2] = mag_line[old_i];
		win_mag[5] = mag_line[mid_i];
		win_mag[8] = m;
		win_dir[2] = dir_line[mid_i];
		mag_line[old_i] = m;
		dir_line[old_i] = d;
		hit = (c >= 2 && rw >= 2);
		r = '0;
		if (hit) begin
			ctr = win_mag[4];
			dc = win_dir[1];
			case (dc)
				DIR_0: begin a = win_mag[3]; b = win_mag[5]; end
				DIR_45: begin a = win_mag[0]; b = win_mag[8]; end
				DIR_90: begin a = win_mag[1]; b = win_mag[7]; end
				default: begin a = win_mag[6]; b = win_mag[2]; end
			endcase
			r.mag = (ctr > a && ctr > b) ? ctr : 16'd0;
			r.col = 11'(c - 1);
			r.row = 12'(rw - 1);
			r.dir = dc;
			r.last = (c == w - 1 && rw == h - 1);
		end
		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
		end else begin
			col_cnt++;
		end
		return hit;
	endfunction

	// offer one request after a random gap (none in burst mode), wait for it to be taken
	task automatic send_pixel(input logic signed [15:0] gx, input logic signed [15:0] gy,
		input logic fs, input bit typed, input nms_result_t want);
		int gap;
		nms_result_t r;
		gap = sender_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.grad_x <= gx;
		pix.grad_y <= gy;
		pix.frame_start <= fs;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		items_sent++;
		if (nms_step(gx, gy, fs, r))
			pending_results.push_back(typed ? want : r);
	endtask

	// drain all results, then let a trailing no-result request finish
	task automatic wait_drained();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [12:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IMAGE_WIDTH) width_reg = v[11:0];
		else height_reg = v;
	endtask

	function automatic logic signed [15:0] rand_grad();
		case ($urandom_range(0, 7))
			0, 1: return 16'($urandom);
			2: return 16'sd0;
			default: return 16'($signed($urandom_range(0, 40)) - 20);
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		nms_result_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", res.suppressed_magnitude, 0);
			end else begin
				e = pending_results.pop_front();
				if (res.suppressed_magnitude !== e.mag)
					report("suppressed_magnitude", res.suppressed_magnitude, e.mag);
				if (res.center_col !== e.col) report("center_col", res.center_col, e.col);
				if (res.center_row !== e.row) report("center_row", res.center_row, e.row);
				if (res.direction_code !== e.dir)
					report("direction_code", res.direction_code, e.dir);
				if (res.last_of_frame !== e.last)
					report("last_of_frame", res.last_of_frame, e.last);
			end
			results_seen++;
		end
	end

	// result side back-pressure, with one long hold-off
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ((results_seen / 64) % 3 == 1) ? 0 : $urandom_range(0, 7);
			if (!held && results_seen >= 150) begin
				held = 1'b1;
				gap = 400;
			end
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			@(posedge clk);
			while (!res.valid) @(posedge clk);
		end
	end

	// run limit
	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// directed table: a lone peak, signed extremes, then a flat tie
	pix_row_t directed_rows [27];

	initial begin
		nms_result_t none;
		int unsigned w, h, n, cut;
		int phase;
		none = '0;
		directed_rows = '{
			'{16'sd0, 16'sd0, 1'b1, 1'b0, '0}, '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd0, 16'sd0, 1'b0, 1'b0, '0}, '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b0, 1'b0, '0}, '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd0, 16'sd0, 1'b0, 1'b0, '0}, '{16'sd0, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd0, 16'sd0, 1'b0, 1'b1, '{16'd5, 11'd1, 12'd1, DIR_45, 1'b1}},
			'{-16'sd32768, -16'sd32768, 1'b1, 1'b0, '0},
			'{16'sd32767, 16'sd32767, 1'b0, 1'b0, '0},
			'{-16'sd32768, 16'sd32767, 1'b0, 1'b0, '0},
			'{16'sd32767, -16'sd32768, 1'b0, 1'b0, '0},
			'{-16'sd32768, -16'sd32768, 1'b0, 1'b0, '0},
			'{16'sd0, -16'sd32768, 1'b0, 1'b0, '0},
			'{-16'sd32768, 16'sd0, 1'b0, 1'b0, '0},
			'{16'sd0, 16'sd5, 1'b0, 1'b0, '0},
			'{16'sd5, -16'sd2, 1'b0, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b1, 1'b0, '0}, '{16'sd3, 16'sd4, 1'b0, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b0, 1'b0, '0}, '{16'sd3, 16'sd4, 1'b0, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b0, 1'b0, '0}, '{16'sd3, 16'sd4, 1'b0, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b0, 1'b0, '0}, '{16'sd3, 16'sd4, 1'b0, 1'b0, '0},
			'{16'sd3, 16'sd4, 1'b0, 1'b1, '{16'd0, 11'd1, 12'd1, DIR_45, 1'b1}}
		};
		width_reg = RST_IMAGE_WIDTH;
		height_reg = RST_IMAGE_HEIGHT;
		foreach (mag_line[i]) begin
			mag_line[i] = '0;
			dir_line[i] = '0;
		end
		foreach (win_mag[i]) win_mag[i] = '0;
		foreach (win_dir[i]) win_dir[i] = '0;
		col_cnt = 0;
		row_cnt = 0;

		// reset and idle inputs
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IMAGE_WIDTH;
		cfg_data <= '0;
		pix.valid <= 1'b0;
		pix.grad_x <= '0;
		pix.grad_y <= '0;
		pix.frame_start <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on the smallest frame
		write_reg(CFG_IMAGE_WIDTH, 13'd3);
		write_reg(CFG_IMAGE_HEIGHT, 13'd3);
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].gx, directed_rows[i].gy, directed_rows[i].fs,
				directed_rows[i].typed, directed_rows[i].want);

		// random frames across settings
		phase = 0;
		while (items_sent < 1900 || phase < 8) begin
			wait_drained();
			case (phase)
				1: begin write_reg(CFG_IMAGE_WIDTH, 13'd0); write_reg(CFG_IMAGE_HEIGHT, 13'd1); end
				3: begin write_reg(CFG_IMAGE_WIDTH, 13'd4095); write_reg(CFG_IMAGE_HEIGHT, 13'd3); end
				5: begin write_reg(CFG_IMAGE_WIDTH, 13'd7); write_reg(CFG_IMAGE_HEIGHT, 13'd8191); end
				6: begin write_reg(CFG_IMAGE_WIDTH, 13'd2048); write_reg(CFG_IMAGE_HEIGHT, 13'd4096); end
				default: begin
					write_reg(CFG_IMAGE_WIDTH, 13'($urandom_range(3, 12)));
					write_reg(CFG_IMAGE_HEIGHT, 13'($urandom_range(3, 7)));
				end
			endcase
			w = eff_width();
			h = eff_height();
			// wide rows get a short run that stays in the top rows
			if (w > 100) n = $urandom_range(20, 60);
			else if (h > 100) n = 3 * w + $urandom_range(0, 20);
			else n = w * h * $urandom_range(1, 3) + $urandom_range(0, w);
			cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : 0;
			sender_burst = (phase % 4 == 2);
			for (int unsigned i = 0; i < n; i++)
				send_pixel(rand_grad(), rand_grad(), (i == 0 || i == cut), 1'b0, none);
			phase++;
		end

		// end of stimulus
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
